// ===== rtl/core/swsr_pkg.sv =====
// Shared types and constants for the single-wire sensor reader.
package swsr_pkg;

  // Bytes collected in one read of the sensor
  localparam int unsigned BYTES_PER_READ = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_START_LOW     = 3'd0;
  localparam logic [2:0] REG_START_HIGH    = 3'd1;
  localparam logic [2:0] REG_RESPONSE_SKIP = 3'd2;
  localparam logic [2:0] REG_BIT_GAP       = 3'd3;
  localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd4;
  localparam logic [2:0] REG_ONE_HOLD      = 3'd5;

  // Register reset values
  localparam logic [19:0] START_LOW_RESET     = 20'd20000;
  localparam logic [15:0] START_HIGH_RESET    = 16'd20;
  localparam logic [15:0] RESPONSE_SKIP_RESET = 16'd80;
  localparam logic [15:0] BIT_GAP_RESET       = 16'd40;
  localparam logic [15:0] SAMPLE_DELAY_RESET  = 16'd30;
  localparam logic [15:0] ONE_HOLD_RESET      = 16'd30;

  // Line drive codes
  localparam logic [1:0] LINE_RELEASE    = 2'd0;
  localparam logic [1:0] LINE_DRIVE_LOW  = 2'd1;
  localparam logic [1:0] LINE_DRIVE_HIGH = 2'd2;

  // Read sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_START_HIGH,
    PH_SKIP_A,
    PH_WAIT_LOW,
    PH_SKIP_B,
    PH_WAIT_HIGH,
    PH_WAIT_END,
    PH_GAP,
    PH_BIT_HIGH,
    PH_DELAY,
    PH_SAMPLE,
    PH_HOLD
  } phase_t;

  // Timing configuration
  typedef struct packed {
    logic [19:0] start_low_ticks;
    logic [15:0] start_high_ticks;
    logic [15:0] response_skip_ticks;
    logic [15:0] bit_gap_ticks;
    logic [15:0] sample_delay_ticks;
    logic [15:0] one_hold_ticks;
  } cfg_t;

  // One tick of input
  typedef struct packed {
    logic command;
    logic line_level;
  } item_t;

  // One tick of result
  typedef struct packed {
    logic [1:0] line_mode;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic       read_done;
    logic       busy_res;
  } result_t;

endpackage

// ===== rtl/core/swsr_regs.sv =====
// Configuration register file for the single-wire sensor reader.
module swsr_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output swsr_pkg::cfg_t     cfg
);

  logic wr;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Register update; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks     <= swsr_pkg::START_LOW_RESET;
      cfg.start_high_ticks    <= swsr_pkg::START_HIGH_RESET;
      cfg.response_skip_ticks <= swsr_pkg::RESPONSE_SKIP_RESET;
      cfg.bit_gap_ticks       <= swsr_pkg::BIT_GAP_RESET;
      cfg.sample_delay_ticks  <= swsr_pkg::SAMPLE_DELAY_RESET;
      cfg.one_hold_ticks      <= swsr_pkg::ONE_HOLD_RESET;
    end else if (wr) begin
      unique case (cfg_index)
        swsr_pkg::REG_START_LOW:     cfg.start_low_ticks     <= cfg_data;
        swsr_pkg::REG_START_HIGH:    cfg.start_high_ticks    <= cfg_data[15:0];
        swsr_pkg::REG_RESPONSE_SKIP: cfg.response_skip_ticks <= cfg_data[15:0];
        swsr_pkg::REG_BIT_GAP:       cfg.bit_gap_ticks       <= cfg_data[15:0];
        swsr_pkg::REG_SAMPLE_DELAY:  cfg.sample_delay_ticks  <= cfg_data[15:0];
        swsr_pkg::REG_ONE_HOLD:      cfg.one_hold_ticks      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/swsr_seq.sv =====
// Read sequencer: phase state, tick counter, bit and byte assembly.
module swsr_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  swsr_pkg::item_t     item,
  input  swsr_pkg::cfg_t      cfg,
  output swsr_pkg::result_t   step
);

  swsr_pkg::phase_t phase, phase_next;
  logic [19:0]      tick_count, tick_next;
  logic [7:0]       shift_byte, shift_next;
  logic [3:0]       bit_count, bit_next;
  logic [2:0]       byte_count, byte_next;

  // Ticks a timed phase lasts
  function automatic logic [19:0] phase_limit(swsr_pkg::phase_t p, swsr_pkg::cfg_t c);
    logic [19:0] lim;
    lim = '0;
    unique case (p)
      swsr_pkg::PH_START_LOW:  lim = c.start_low_ticks;
      swsr_pkg::PH_START_HIGH: lim = {4'b0, c.start_high_ticks};
      swsr_pkg::PH_SKIP_A,
      swsr_pkg::PH_SKIP_B:     lim = {4'b0, c.response_skip_ticks};
      swsr_pkg::PH_GAP:        lim = {4'b0, c.bit_gap_ticks};
      swsr_pkg::PH_DELAY:      lim = {4'b0, c.sample_delay_ticks};
      swsr_pkg::PH_HOLD:       lim = {4'b0, c.one_hold_ticks};
      default:                 lim = '0;
    endcase
    return lim;
  endfunction

  // Phase that follows a timed phase
  function automatic swsr_pkg::phase_t timed_next(swsr_pkg::phase_t p);
    swsr_pkg::phase_t n;
    n = swsr_pkg::PH_IDLE;
    unique case (p)
      swsr_pkg::PH_START_LOW:  n = swsr_pkg::PH_START_HIGH;
      swsr_pkg::PH_START_HIGH: n = swsr_pkg::PH_SKIP_A;
      swsr_pkg::PH_SKIP_A:     n = swsr_pkg::PH_WAIT_LOW;
      swsr_pkg::PH_SKIP_B:     n = swsr_pkg::PH_WAIT_HIGH;
      swsr_pkg::PH_GAP:        n = swsr_pkg::PH_BIT_HIGH;
      swsr_pkg::PH_DELAY:      n = swsr_pkg::PH_SAMPLE;
      default:                 n = swsr_pkg::PH_IDLE;
    endcase
    return n;
  endfunction

  // Skip, gap and delay phases of zero length fall through to the phase that follows
  function automatic swsr_pkg::phase_t enter_phase(swsr_pkg::phase_t p, swsr_pkg::cfg_t c);
    swsr_pkg::phase_t n;
    n = p;
    unique case (p)
      swsr_pkg::PH_SKIP_A,
      swsr_pkg::PH_SKIP_B: if (c.response_skip_ticks == '0) n = timed_next(p);
      swsr_pkg::PH_GAP:    if (c.bit_gap_ticks == '0) n = timed_next(p);
      swsr_pkg::PH_DELAY:  if (c.sample_delay_ticks == '0) n = timed_next(p);
      default:             n = p;
    endcase
    return n;
  endfunction

  swsr_pkg::phase_t eff_phase;
  logic [19:0]      eff_tick;
  logic [19:0]      tick_inc;
  logic [7:0]       eff_shift;
  logic [3:0]       eff_bit;
  logic [2:0]       eff_byte;
  logic [3:0]       bit_inc;
  logic [3:0]       byte_inc;
  logic             do_finish;

  // One tick of the sequencer
  always_comb begin
    // A start command restarts the read on this same tick
    if (item.command) begin
      eff_phase = swsr_pkg::PH_START_LOW;
      eff_tick  = '0;
      eff_shift = '0;
      eff_bit   = '0;
      eff_byte  = '0;
    end else begin
      eff_phase = phase;
      eff_tick  = tick_count;
      eff_shift = shift_byte;
      eff_bit   = bit_count;
      eff_byte  = byte_count;
    end

    phase_next = eff_phase;
    tick_next  = eff_tick;
    shift_next = eff_shift;
    bit_next   = eff_bit;
    byte_next  = eff_byte;
    tick_inc   = eff_tick + 20'd1;
    bit_inc    = eff_bit + 4'd1;
    byte_inc   = {1'b0, eff_byte} + 4'd1;
    do_finish  = 1'b0;

    step = '0;
    if (eff_phase == swsr_pkg::PH_START_LOW) begin
      step.line_mode = swsr_pkg::LINE_DRIVE_LOW;
    end else if (eff_phase == swsr_pkg::PH_START_HIGH) begin
      step.line_mode = swsr_pkg::LINE_DRIVE_HIGH;
    end else begin
      step.line_mode = swsr_pkg::LINE_RELEASE;
    end
    step.busy_res = (eff_phase != swsr_pkg::PH_IDLE);

    unique case (eff_phase)
      swsr_pkg::PH_START_LOW, swsr_pkg::PH_START_HIGH, swsr_pkg::PH_SKIP_A,
      swsr_pkg::PH_SKIP_B, swsr_pkg::PH_GAP, swsr_pkg::PH_DELAY,
      swsr_pkg::PH_HOLD: begin
        tick_next = tick_inc;
        if (tick_inc >= phase_limit(eff_phase, cfg)) begin
          tick_next = '0;
          if (eff_phase == swsr_pkg::PH_HOLD) begin
            do_finish = 1'b1;
          end else begin
            phase_next = enter_phase(timed_next(eff_phase), cfg);
          end
        end
      end
      swsr_pkg::PH_WAIT_LOW: begin
        if (!item.line_level) begin
          phase_next = enter_phase(swsr_pkg::PH_SKIP_B, cfg);
          tick_next  = '0;
        end
      end
      swsr_pkg::PH_WAIT_HIGH: begin
        if (item.line_level) begin
          phase_next = swsr_pkg::PH_WAIT_END;
          tick_next  = '0;
        end
      end
      swsr_pkg::PH_WAIT_END: begin
        if (!item.line_level) begin
          phase_next = enter_phase(swsr_pkg::PH_GAP, cfg);
          tick_next  = '0;
        end
      end
      swsr_pkg::PH_BIT_HIGH: begin
        if (item.line_level) begin
          phase_next = enter_phase(swsr_pkg::PH_DELAY, cfg);
          tick_next  = '0;
        end
      end
      swsr_pkg::PH_SAMPLE: begin
        shift_next = {eff_shift[6:0], item.line_level};
        if (item.line_level && (cfg.one_hold_ticks != '0)) begin
          phase_next = swsr_pkg::PH_HOLD;
          tick_next  = '0;
        end else begin
          do_finish = 1'b1;
        end
      end
      default: begin
        phase_next = swsr_pkg::PH_IDLE;
        tick_next  = '0;
      end
    endcase

    // End of a bit: next bit, or byte complete
    if (do_finish) begin
      if (bit_inc < 4'd8) begin
        bit_next   = bit_inc;
        phase_next = enter_phase(swsr_pkg::PH_GAP, cfg);
        tick_next  = '0;
      end else begin
        step.byte_valid = 1'b1;
        step.byte_value = shift_next;
        step.byte_index = eff_byte;
        shift_next      = '0;
        bit_next        = '0;
        tick_next       = '0;
        if (byte_inc >= 4'(swsr_pkg::BYTES_PER_READ)) begin
          step.read_done = 1'b1;
          byte_next      = '0;
          phase_next     = swsr_pkg::PH_IDLE;
        end else begin
          byte_next  = byte_inc[2:0];
          phase_next = enter_phase(swsr_pkg::PH_GAP, cfg);
        end
      end
    end
  end

  // Sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= swsr_pkg::PH_IDLE;
      tick_count <= '0;
      shift_byte <= '0;
      bit_count  <= '0;
      byte_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_next;
      shift_byte <= shift_next;
      bit_count  <= bit_next;
      byte_count <= byte_next;
    end
  end

endmodule

// ===== rtl/core/swsr_out.sv =====
// Result register with stall-driven flow control.
module swsr_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  swsr_pkg::result_t  step,
  output logic               result_valid,
  input  logic               result_stall,
  output swsr_pkg::result_t  result,
  output logic               hold
);

  // Upstream must wait only while a stalled result sits here
  assign hold = result_valid && result_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= step;
    end
  end

endmodule

// ===== rtl/core/single_wire_sensor_reader.sv =====
// Single-wire sensor reader top level: one result per one-microsecond line sample.
// Each transfer on the item channel is one 1 us tick carrying the sampled line
// level and an optional start command; every tick yields exactly one registered
// result giving the line drive, read status and any byte completed on that tick.
// The block takes one tick per clock cycle while item_stall is low: the sequencer
// updates its phase, counter and shift register on each accepted tick and the
// result register takes a new tick on the same edge its previous result leaves.
// item_stall rises only while a result is held by result_stall. Timing registers
// are written on the cfg channel (always ready); the user must write them only
// while no tick is in flight, as the block itself does not enforce it.
module single_wire_sensor_reader (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  swsr_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output swsr_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  swsr_pkg::cfg_t    cfg;
  swsr_pkg::result_t step;
  logic              accept;

  assign accept = item_valid && !item_stall;

  // Timing registers
  swsr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Read sequencer
  swsr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .step   (step)
  );

  // Result register
  swsr_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .step         (step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .hold         (item_stall)
  );

endmodule

// ===== rtl/core/swsr_checker.sv =====
// Port-level checks for the single-wire sensor reader, bound to the top level.
module swsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input swsr_pkg::item_t    item,
  input logic               result_valid,
  input logic               result_stall,
  input swsr_pkg::result_t  result
);

  // A stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A start command shows up as the start of the low pulse
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.command |=>
      result_valid && result.busy_res &&
      (result.line_mode == swsr_pkg::LINE_DRIVE_LOW))
    else $error("start command did not begin low pulse");

  // Idle ticks release the line and carry no byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.busy_res |->
      (result.line_mode == swsr_pkg::LINE_RELEASE) && !result.byte_valid)
    else $error("idle result drives line or carries byte");

  // Byte fields are zero with no byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.byte_valid |->
      (result.byte_value == '0) && (result.byte_index == '0) && !result.read_done)
    else $error("byte fields set without a byte");

  // Last byte of a read has the last index
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_done |->
      result.byte_valid &&
      (result.byte_index == 3'(swsr_pkg::BYTES_PER_READ - 1)))
    else $error("read done on wrong byte");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
